FILE: rtl/selective_repeat_sender_window_assert.svh
// assertion macros for the selective-repeat sender window
// expects a clock i_clk and an active-low reset i_rst_n in the using scope
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SRSW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SRSW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/srsw_pkg.sv
// shared types, constants and helpers for the selective-repeat sender window
// no dependencies
`timescale 1ns / 1ps

package srsw_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int SEQ_W        = 8;
    localparam int SLOT_W       = 6;
    localparam int CELL_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int KIND_W       = 3;
    localparam int MODE_W       = 2;

    localparam logic [SLOT_W-1:0] OFFSET_RESET = SLOT_W'(10);

    typedef logic [SEQ_W-1:0]  t_seq;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CELL_W-1:0] t_cell;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_SENT  = 2'd1,
        ST_ACKED = 2'd2
    } t_status;

    typedef enum logic [MODE_W-1:0] {
        MODE_NEW    = 2'd0,
        MODE_RESEND = 2'd1,
        MODE_ACK    = 2'd2,
        MODE_TICK   = 2'd3
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEND_OK    = 3'd0,
        KIND_ACK_OK     = 3'd1,
        KIND_ACK_IGN    = 3'd2,
        KIND_RESEND_REQ = 3'd3,
        KIND_TICK_DONE  = 3'd4
    } t_kind;

    // one cell memory entry
    typedef struct packed {
        t_seq  seq;
        t_slot slot;
    } t_entry;

    // status and timer-flag updates for one cycle
    typedef struct packed {
        logic  sent_en;
        t_cell sent_cell;
        logic  ack_en;
        t_cell ack_cell;
        logic  empty_en;
        t_cell empty_cell;
        logic  tv_clr_en;
        t_cell tv_clr_cell;
    } t_stat_upd;

    // window cell of a sequence number (depth is a power of two)
    function automatic t_cell cell_of(input t_seq s);
        return s[CELL_W-1:0];
    endfunction

endpackage

FILE: rtl/srsw_cell_mem.sv
// cell memory: stored sequence number and armed wheel slot per window cell
// depends on srsw_pkg; one write port, one read port with registered data
`timescale 1ns / 1ps

module srsw_cell_mem
    import srsw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_wr_en,
    input  t_cell  i_wr_addr,
    input  t_entry i_wr_data,
    input  t_cell  i_rd_addr,
    output t_entry o_rd_data
);

    t_entry r_mem [WINDOW_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/srsw_status.sv
// per-cell status and timer-armed flags, cleared by reset
// depends on srsw_pkg; updated through a t_stat_upd bundle
`timescale 1ns / 1ps

module srsw_status
    import srsw_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_stat_upd               i_upd,
    output t_status                 o_status [WINDOW_DEPTH],
    output logic [WINDOW_DEPTH-1:0] o_tv
);

    t_status                 r_status [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] r_tv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_status[i] <= ST_EMPTY;
            end
            r_tv <= '0;
        end else begin
            if (i_upd.sent_en) begin
                r_status[i_upd.sent_cell] <= ST_SENT;
                r_tv[i_upd.sent_cell]     <= 1'b1;
            end
            if (i_upd.ack_en) begin
                r_status[i_upd.ack_cell] <= ST_ACKED;
            end
            if (i_upd.empty_en) begin
                r_status[i_upd.empty_cell] <= ST_EMPTY;
            end
            if (i_upd.tv_clr_en) begin
                r_tv[i_upd.tv_clr_cell] <= 1'b0;
            end
        end
    end

    assign o_status = r_status;
    assign o_tv     = r_tv;

endmodule

FILE: rtl/selective_repeat_sender_window.sv
// selective-repeat sender window with timer wheel, one item at a time, taken only in S_IDLE
// send goes through S_SEND and an ignored ack through S_ACK_OUT to the registered result;
// an accepted ack runs S_ACK_CHK, S_ACK_SLIDE (base slides over 0 to 16 cells) and S_ACK_OUT;
// a tick runs S_TICK_SCAN (16-cell scan), then the done beat in S_TICK_DONE; a result waits
// while the consumer stalls; the block takes no new item until the last one is done
// sync active-low reset empties cells, disarms timers, zeroes counters, offset 10; no mem clear
`timescale 1ns / 1ps

`include "selective_repeat_sender_window_assert.svh"

module selective_repeat_sender_window
    import srsw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: timeout_offset
    input  logic              i_cfg_wr_en,
    input  logic [SLOT_W-1:0] i_cfg_wr_data,
    // input channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [SEQ_W-1:0]  i_seq_num,
    // output channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic [KIND_W-1:0] o_kind,
    output logic [SEQ_W-1:0]  o_out_seq,
    output logic [SEQ_W-1:0]  o_send_base_now,
    output logic [SEQ_W-1:0]  o_next_seq_now,
    output logic              o_last
);

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_SEND      = 7'b0000010,
        S_ACK_CHK   = 7'b0000100,
        S_ACK_SLIDE = 7'b0001000,
        S_ACK_OUT   = 7'b0010000,
        S_TICK_SCAN = 7'b0100000,
        S_TICK_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // item being worked on
    t_mode  r_mode, n_mode;
    t_seq   r_seq, n_seq;
    logic   r_ack_ok, n_ack_ok;
    // cell address: ack target or scan index; the memory reads at its next value,
    // so the registered read data always belongs to r_addr
    t_cell  r_addr, n_addr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // window and wheel state
    t_seq   r_base, n_base;
    t_seq   r_next, n_next;
    t_slot  r_cur, n_cur;
    t_slot  r_offset;

    // output register
    logic   r_o_valid;
    t_kind  r_o_kind;
    t_seq   r_o_seq;
    t_seq   r_o_base;
    t_seq   r_o_next;
    logic   r_o_last;

    // per-beat load of the output register
    logic   ld;
    t_kind  ld_kind;
    t_seq   ld_seq;
    logic   ld_last;

    logic      out_free;
    t_slot     arm_pos;
    t_cell     in_cell;
    t_cell     base_cell;
    logic      scan_hit;
    t_status   st_in;

    t_stat_upd upd;
    logic      mem_we;
    t_entry    mem_wdata;
    t_entry    mem_rdata;
    t_status   status [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] tv;

    // ---------------------------------------------------------------
    // state stores
    // ---------------------------------------------------------------
    srsw_cell_mem u_cell_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_addr),
        .i_wr_data (mem_wdata),
        .i_rd_addr (n_addr),
        .o_rd_data (mem_rdata)
    );

    srsw_status u_status (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (upd),
        .o_status (status),
        .o_tv     (tv)
    );

    // ---------------------------------------------------------------
    // helpers
    // ---------------------------------------------------------------
    // output register can take a beat if empty or being drained now
    assign out_free  = !r_o_valid || i_ready;
    // slot a send would arm right now, wraps with the wheel
    assign arm_pos   = r_cur + r_offset;
    assign in_cell   = cell_of(i_seq_num);
    assign base_cell = cell_of(r_base);
    assign st_in     = status[in_cell];
    // armed timer whose slot matches the current wheel position
    assign scan_hit  = tv[r_addr] && (mem_rdata.slot == r_cur);
    assign mem_wdata = '{seq: r_seq, slot: arm_pos};

    assign o_ready = (r_state == S_IDLE);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_seq    = r_seq;
        n_ack_ok = r_ack_ok;
        n_addr   = r_addr;
        n_cnt    = r_cnt;
        n_base   = r_base;
        n_next   = r_next;
        n_cur    = r_cur;
        upd      = '0;
        mem_we   = 1'b0;
        ld       = 1'b0;
        ld_kind  = KIND_TICK_DONE;
        ld_seq   = '0;
        ld_last  = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode = t_mode'(i_mode);
                    n_seq  = i_seq_num;
                    n_addr = in_cell;
                    unique case (t_mode'(i_mode))
                        MODE_NEW, MODE_RESEND: begin
                            n_state = S_SEND;
                        end
                        MODE_ACK: begin
                            // only an outstanding cell is acknowledged
                            n_ack_ok = (st_in != ST_EMPTY) && (st_in != ST_ACKED);
                            n_state  = ((st_in != ST_EMPTY) && (st_in != ST_ACKED)) ?
                                       S_ACK_CHK : S_ACK_OUT;
                        end
                        MODE_TICK: begin
                            n_addr  = '0;
                            n_state = S_TICK_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // write the cell, arm its timer and report in one go
            S_SEND: begin
                if (out_free) begin
                    mem_we        = 1'b1;
                    upd.sent_en   = 1'b1;
                    upd.sent_cell = r_addr;
                    if (r_mode == MODE_NEW) begin
                        n_next = r_next + SEQ_W'(1);
                    end
                    ld      = 1'b1;
                    ld_kind = KIND_SEND_OK;
                    ld_seq  = r_seq;
                    n_state = S_IDLE;
                end
            end

            // slot of the acked cell is in from memory: mark acked, cancel
            // the timer unless it sits at the current arm position
            S_ACK_CHK: begin
                upd.ack_en   = 1'b1;
                upd.ack_cell = r_addr;
                if (arm_pos != mem_rdata.slot) begin
                    upd.tv_clr_en   = 1'b1;
                    upd.tv_clr_cell = r_addr;
                end
                n_cnt   = '0;
                n_state = S_ACK_SLIDE;
            end

            // one cell per cycle, at most a full window
            S_ACK_SLIDE: begin
                if ((r_cnt != CNT_W'(WINDOW_DEPTH)) && (status[base_cell] == ST_ACKED)) begin
                    upd.empty_en   = 1'b1;
                    upd.empty_cell = base_cell;
                    n_base         = r_base + SEQ_W'(1);
                    n_cnt          = r_cnt + CNT_W'(1);
                end else begin
                    n_state = S_ACK_OUT;
                end
            end

            S_ACK_OUT: begin
                if (out_free) begin
                    ld      = 1'b1;
                    ld_kind = r_ack_ok ? KIND_ACK_OK : KIND_ACK_IGN;
                    ld_seq  = r_seq;
                    n_state = S_IDLE;
                end
            end

            // scan cells in ascending order; a hit waits for a free output beat
            S_TICK_SCAN: begin
                if (!scan_hit || out_free) begin
                    if (scan_hit) begin
                        ld              = 1'b1;
                        ld_kind         = KIND_RESEND_REQ;
                        ld_seq          = mem_rdata.seq;
                        ld_last         = 1'b0;
                        upd.tv_clr_en   = 1'b1;
                        upd.tv_clr_cell = r_addr;
                    end
                    if (r_addr == CELL_W'(WINDOW_DEPTH - 1)) begin
                        n_state = S_TICK_DONE;
                    end else begin
                        n_addr = r_addr + CELL_W'(1);
                    end
                end
            end

            S_TICK_DONE: begin
                if (out_free) begin
                    ld      = 1'b1;
                    ld_kind = KIND_TICK_DONE;
                    ld_seq  = '0;
                    n_cur   = r_cur + SLOT_W'(1);
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= '0;
            r_next   <= '0;
            r_cur    <= '0;
            r_offset <= OFFSET_RESET;
            r_addr   <= '0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_next  <= n_next;
            r_cur   <= n_cur;
            r_addr  <= n_addr;
            r_cnt   <= n_cnt;
            if (i_cfg_wr_en) begin
                r_offset <= i_cfg_wr_data;
            end
        end
    end

    // item payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_seq    <= n_seq;
        r_ack_ok <= n_ack_ok;
    end

    // output register: holds a beat until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ld) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_o_kind <= ld_kind;
            r_o_seq  <= ld_seq;
            r_o_base <= n_base;
            r_o_next <= n_next;
            r_o_last <= ld_last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_kind          = r_o_kind;
    assign o_out_seq       = r_o_seq;
    assign o_send_base_now = r_o_base;
    assign o_next_seq_now  = r_o_next;
    assign o_last          = r_o_last;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // a new item never enters while a non-final beat of the last one is pending
    `SRSW_ASSERT_NOW(a_no_accept_mid_item, i_valid && o_ready, !(o_valid && !o_last), "accepted while a non-final beat waits")
    // tick-done always closes its item, retransmit requests never do
    `SRSW_ASSERT_NOW(a_last_matches_kind, o_valid, (o_last == (o_kind != KIND_RESEND_REQ)), "last flag does not match result kind")
    // the base slide never runs past one window
    `SRSW_ASSERT_NOW(a_slide_bounded, r_state == S_ACK_SLIDE, r_cnt <= CNT_W'(WINDOW_DEPTH), "send base slid past a full window")
    // a completed tick moves the wheel by one slot
    `SRSW_ASSERT_NEXT(a_wheel_step, (r_state == S_TICK_DONE) && out_free, r_cur == $past(r_cur) + SLOT_W'(1), "wheel did not advance after tick")

endmodule

FILE: tb/tb.sv
// self-checking testbench for selective_repeat_sender_window
// needs srsw_pkg and the block's rtl; a predictor in here mirrors the window and timer wheel
`timescale 1ns / 1ps

module tb;
    import srsw_pkg::*;

    localparam int CYCLE_LIMIT = 700000;
    localparam int DRAIN_CYCLES = 60;  // longer than the slowest tick or ack slide
    localparam int QUIET_TAIL = 40;    // ops left when idling stops

    // one queued operation: either a data beat or a write to timeout_offset
    typedef struct {
        bit    is_cfg;
        t_slot cfg;
        t_mode mode;
        t_seq  seq;
    } t_window_op;

    // one predicted output beat
    typedef struct {
        t_kind kind;
        t_seq  seq;
        t_seq  base;
        t_seq  nxt;
        logic  last;
    } t_window_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [SLOT_W-1:0] i_cfg_wr_data;
    logic              i_valid;
    logic              o_ready;
    logic [MODE_W-1:0] i_mode;
    logic [SEQ_W-1:0]  i_seq_num;
    logic              o_valid;
    logic              i_ready;
    logic [KIND_W-1:0] o_kind;
    logic [SEQ_W-1:0]  o_out_seq;
    logic [SEQ_W-1:0]  o_send_base_now;
    logic [SEQ_W-1:0]  o_next_seq_now;
    logic              o_last;

    selective_repeat_sender_window dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_seq_num       (i_seq_num),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_out_seq       (o_out_seq),
        .o_send_base_now (o_send_base_now),
        .o_next_seq_now  (o_next_seq_now),
        .o_last          (o_last)
    );

    // ------------------------------------------------------------------
    // clock and reset: reset held low from the start, then released for good
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // shadow of the window: cell status, stored seq, timers, wheel, counters
    // ------------------------------------------------------------------
    t_status win_status [WINDOW_DEPTH];
    t_seq    win_seq    [WINDOW_DEPTH];
    bit      tmr_armed  [WINDOW_DEPTH];
    t_slot   tmr_slot   [WINDOW_DEPTH];
    t_slot   wheel_pos;
    t_seq    base_seq;
    t_seq    next_new_seq;
    t_slot   offset_cfg;

    t_window_result due_results[$];
    t_window_op     pending_ops[$];

    int results_due;    // pushed by the driver only
    int results_seen;   // nonblocking count kept by the monitor
    int errors;
    int cycles;
    bit quiet_q;

    task automatic window_clear();
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win_status[i] = ST_EMPTY;
            win_seq[i]    = '0;
            tmr_armed[i]  = 1'b0;
            tmr_slot[i]   = '0;
        end
        wheel_pos    = '0;
        base_seq     = '0;
        next_new_seq = '0;
        offset_cfg   = OFFSET_RESET;
    endtask

    task automatic push_result(input t_kind k, input t_seq s, input logic lst);
        t_window_result r;
        r.kind = k;
        r.seq  = s;
        r.base = base_seq;
        r.nxt  = next_new_seq;
        r.last = lst;
        due_results.push_back(r);
        results_due++;
    endtask

    // expected beats for one accepted input beat
    task automatic window_step(input t_mode m, input t_seq s);
        t_cell idx;
        t_cell bidx;
        t_slot arm_at;
        idx    = t_cell'(s);
        arm_at = t_slot'(wheel_pos + offset_cfg);  // wraps at wheel size
        case (m)
            MODE_NEW, MODE_RESEND: begin
                // an occupied cell is simply overwritten and re-armed
                win_status[idx] = ST_SENT;
                win_seq[idx]    = s;
                tmr_armed[idx]  = 1'b1;
                tmr_slot[idx]   = arm_at;
                if (m == MODE_NEW) next_new_seq = next_new_seq + 1'b1;
                push_result(KIND_SEND_OK, s, 1'b1);
            end
            MODE_ACK: begin
                if (win_status[idx] == ST_EMPTY || win_status[idx] == ST_ACKED) begin
                    push_result(KIND_ACK_IGN, s, 1'b1);
                end else begin
                    win_status[idx] = ST_ACKED;
                    // a timer sitting at the current arm slot survives the ack
                    if (arm_at != tmr_slot[idx]) tmr_armed[idx] = 1'b0;
                    for (int i = 0; i < WINDOW_DEPTH; i++) begin
                        bidx = t_cell'(base_seq);
                        if (win_status[bidx] != ST_ACKED) break;
                        win_status[bidx] = ST_EMPTY;
                        base_seq = base_seq + 1'b1;
                    end
                    push_result(KIND_ACK_OK, s, 1'b1);
                end
            end
            default: begin
                // tick: expiries in ascending cell order, then the done beat
                for (int i = 0; i < WINDOW_DEPTH; i++) begin
                    if (tmr_armed[i] && tmr_slot[i] == wheel_pos) begin
                        tmr_armed[i] = 1'b0;
                        push_result(KIND_RESEND_REQ, win_seq[i], 1'b0);
                    end
                end
                wheel_pos = wheel_pos + 1'b1;
                push_result(KIND_TICK_DONE, '0, 1'b1);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 100) $display("tb: mismatch at %0t: %s", $time, what);
    endtask

    task automatic check_field(input string nm, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", nm, got, want));
    endtask

    // ------------------------------------------------------------------
    // driver: feeds beats and config writes from the pending queue;
    // a config write waits until every expected result has come back
    // ------------------------------------------------------------------
    int gap_left;

    always @(posedge i_clk) begin
        t_window_op op;
        logic accepted;
        logic raise;
        logic wr;
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            i_mode        <= MODE_NEW;
            i_seq_num     <= '0;
            i_cfg_wr_en   <= 1'b0;
            i_cfg_wr_data <= '0;
            quiet_q       <= 1'b0;
            gap_left      = 0;
            results_due   = 0;
            window_clear();
        end else begin
            accepted = i_valid && o_ready;
            if (accepted) window_step(t_mode'(i_mode), i_seq_num);
            raise = 1'b0;
            wr    = 1'b0;
            if (i_valid && !accepted) begin
                raise = 1'b1;  // beat still waiting, hold it
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_ops.size() > 0) begin
                if (pending_ops[0].is_cfg) begin
                    // block is idle once everything predicted has been seen
                    if (results_due == results_seen) begin
                        op = pending_ops.pop_front();
                        wr = 1'b1;
                        i_cfg_wr_data <= op.cfg;
                        offset_cfg = op.cfg;
                    end
                end else if (!quiet_q && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(0, 17);  // idle burst of random length
                end else begin
                    op = pending_ops.pop_front();
                    raise = 1'b1;
                    i_mode    <= op.mode;
                    i_seq_num <= op.seq;
                end
            end
            i_valid     <= raise;
            i_cfg_wr_en <= wr;
            quiet_q     <= (pending_ops.size() < QUIET_TAIL);
        end
    end

    // ------------------------------------------------------------------
    // monitor: random ready stalls, compare each beat against the oldest
    // expectation
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge i_clk) begin
        t_window_result exp_r;
        logic rdy;
        if (!i_rst_n) begin
            i_ready      <= 1'b0;
            results_seen <= 0;
            stall_left   = 0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen <= results_seen + 1;
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat kind %0d seq %0h",
                                              o_kind, o_out_seq));
                end else begin
                    exp_r = due_results.pop_front();
                    check_field("kind", 8'(o_kind), 8'(exp_r.kind));
                    check_field("out_seq", o_out_seq, exp_r.seq);
                    check_field("send_base_now", o_send_base_now, exp_r.base);
                    check_field("next_seq_now", o_next_seq_now, exp_r.nxt);
                    check_field("last", 8'(o_last), 8'(exp_r.last));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!quiet_q && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 17);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_ready <= rdy;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    t_seq gen_next;  // generator's idea of next_seq, to aim sends and acks

    task automatic add_beat(input t_mode m, input t_seq s);
        t_window_op op;
        op.is_cfg = 1'b0;
        op.cfg    = '0;
        op.mode   = m;
        op.seq    = s;
        pending_ops.push_back(op);
        if (m == MODE_NEW) gen_next = gen_next + 1'b1;
    endtask

    task automatic add_cfg(input t_slot v);
        t_window_op op;
        op.is_cfg = 1'b1;
        op.cfg    = v;
        op.mode   = MODE_NEW;
        op.seq    = '0;
        pending_ops.push_back(op);
    endtask

    // mostly well-formed traffic around the live window, some noise
    task automatic add_random_phase(input t_slot off, input int n);
        int count;
        int r;
        int run;
        count = 0;
        add_cfg(off);
        while (count < n) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                add_beat(t_mode'($urandom_range(0, 3)), t_seq'($urandom_range(0, 255)));
                count++;
            end else if (r < 38) begin
                add_beat(MODE_NEW, gen_next);
                count++;
            end else if (r < 50) begin
                add_beat(MODE_RESEND, t_seq'(int'(gen_next) - 1 - $urandom_range(0, 15)));
                count++;
            end else if (r < 75) begin
                add_beat(MODE_ACK, t_seq'(int'(gen_next) - 1 - $urandom_range(0, 17)));
                count++;
            end else begin
                // short tick runs, now and then one long enough to reach the timeouts
                run = (r >= 97) ? int'(off) + 1 : $urandom_range(1, 4);
                repeat (run) add_beat(MODE_TICK, t_seq'($urandom_range(0, 255)));
                count += run;
            end
        end
    endtask

    initial begin
        errors   = 0;
        cycles   = 0;
        gen_next = '0;

        // directed part, offset at its reset value
        add_beat(MODE_ACK, 8'd0);       // ack of an empty cell
        add_beat(MODE_TICK, 8'hff);     // tick with nothing armed
        add_beat(MODE_NEW, 8'd0);
        add_beat(MODE_NEW, 8'd1);
        add_beat(MODE_ACK, 8'd1);       // timer at the arm slot stays armed
        add_beat(MODE_ACK, 8'd1);       // ack of an acked cell
        add_beat(MODE_ACK, 8'd0);       // base slides over two cells
        add_beat(MODE_NEW, 8'd2);
        add_beat(MODE_RESEND, 8'd2);    // send onto an occupied cell
        add_beat(MODE_NEW, 8'd255);     // top cell, seq away from next_seq
        add_beat(MODE_ACK, 8'd18);      // seq differs from the stored one
        // walk the wheel past the arm slot: several expiries in one tick,
        // including cells already acked
        repeat (12) add_beat(MODE_TICK, 8'd0);

        // zero offset: the timer lands in the current slot
        add_cfg(6'd0);
        add_beat(MODE_NEW, gen_next);
        add_beat(MODE_ACK, t_seq'(gen_next - 1'b1));
        add_beat(MODE_TICK, 8'd0);
        add_beat(MODE_NEW, gen_next);
        add_beat(MODE_TICK, 8'd0);

        // random part over several offsets, extremes included
        add_random_phase(6'd1, 48);
        add_random_phase(6'd63, 48);
        add_random_phase(t_slot'($urandom_range(1, 63)), 46);
        add_random_phase(6'd0, 46);
        add_random_phase(t_slot'($urandom_range(1, 63)), 46);
        add_random_phase(OFFSET_RESET, 46);

        @(posedge i_rst_n);
        do @(negedge i_clk);
        while (!(pending_ops.size() == 0 && !i_valid && results_due == results_seen));
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (due_results.size() != 0) report_mismatch("expected beats never arrived");

        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/srsw_pkg.sv
rtl/srsw_cell_mem.sv
rtl/srsw_status.sv
rtl/selective_repeat_sender_window.sv
tb/tb.sv
